// ===== rtl/mss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_pkg: shared types and constants for the maximal set registry
// Function and status codes, engine states and the result bundle passed
// from the scan engine to the output register.
// ----------------------------------------------------------------------------
package mss_pkg;

    localparam int SET_W         = 64;
    localparam int MAX_ITEMS_DEF = 64;
    localparam int CAPACITY_DEF  = 256;

    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 8;
    localparam int COUNT_W   = 9;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED = 2'd0,
        STAT_COVERED  = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_QUERY    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PRUNE,
        ST_PLACE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        status_t             status;
        logic                covered;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  removed_count;
        logic [COUNT_W-1:0]  live_count;
    } result_t;

endpackage

// ===== rtl/mss_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_table: set storage memory
// One write port and one read port with registered read data. Each word
// holds a valid flag above the item bitmap.
// ----------------------------------------------------------------------------
module mss_table #(
    parameter int MAX_ITEMS = mss_pkg::MAX_ITEMS_DEF,
    parameter int CAPACITY  = mss_pkg::CAPACITY_DEF,
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic [MAX_ITEMS:0]   rd_data,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [MAX_ITEMS:0]   wr_data
);
    import mss_pkg::*;

    logic [MAX_ITEMS:0] mem [CAPACITY];
    logic [MAX_ITEMS:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/mss_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_engine: table scan sequencer
// Runs the cover scan, the prune scan with free-slot search and the final
// placement over the set memory, and holds the table bookkeeping.
// ----------------------------------------------------------------------------
module mss_engine #(
    parameter int MAX_ITEMS = mss_pkg::MAX_ITEMS_DEF,
    parameter int CAPACITY  = mss_pkg::CAPACITY_DEF,
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic                     func,
    input  logic [mss_pkg::SET_W-1:0] item_set,
    output logic                     rd_en,
    output logic [AW-1:0]            rd_addr,
    input  logic [MAX_ITEMS:0]       rd_data,
    output logic                     wr_en,
    output logic [AW-1:0]            wr_addr,
    output logic [MAX_ITEMS:0]       wr_data,
    input  logic                     out_ready,
    output logic                     done,
    output mss_pkg::result_t         result
);
    import mss_pkg::*;

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    state_t                 state_reg, state_next;
    logic                   func_reg, func_next;
    logic [MAX_ITEMS-1:0]   set_reg, set_next;
    logic [CW-1:0]          issue_reg, issue_next;
    logic                   pend_reg, pend_next;
    logic [CW-1:0]          pend_idx_reg, pend_idx_next;
    logic                   covered_reg, covered_next;
    logic                   found_reg, found_next;
    logic [CW-1:0]          target_reg, target_next;
    logic [CW-1:0]          removed_reg, removed_next;
    logic [CW-1:0]          live_reg, live_next;
    logic [CW-1:0]          hw_reg, hw_next;
    status_t                status_reg, status_next;

    logic                   issue_more;
    logic                   pass_done;
    logic                   entry_valid;
    logic [MAX_ITEMS-1:0]   entry_set;
    logic                   sup_hit;
    logic                   sub_hit;
    logic                   room;

    assign issue_more  = issue_reg < hw_reg;
    assign pass_done   = !issue_more && !pend_reg;
    assign entry_valid = rd_data[MAX_ITEMS];
    assign entry_set   = rd_data[MAX_ITEMS-1:0];
    assign sup_hit     = pend_reg && entry_valid && ((set_reg & ~entry_set) == '0);
    assign sub_hit     = pend_reg && entry_valid && ((entry_set & ~set_reg) == '0);
    assign room        = hw_reg < CAP_C;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (pass_done)
                begin
                    if (func_reg == FUNC_QUERY || covered_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_PRUNE;
                    end
                end
            end
            ST_PRUNE:
            begin
                if (pass_done)
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_stall = 1'b1;
        rd_en     = 1'b0;
        rd_addr   = issue_reg[AW-1:0];
        wr_en     = 1'b0;
        wr_addr   = pend_idx_reg[AW-1:0];
        wr_data   = {1'b0, entry_set};
        done      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            ST_SCAN:
            begin
                rd_en = issue_more;
            end
            ST_PRUNE:
            begin
                rd_en = issue_more;
                wr_en = sub_hit;
            end
            ST_PLACE:
            begin
                wr_en   = found_reg || room;
                wr_addr = found_reg ? target_reg[AW-1:0] : hw_reg[AW-1:0];
                wr_data = {1'b1, set_reg};
            end
            ST_FINISH:
            begin
                done = out_ready;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        func_next     = func_reg;
        set_next      = set_reg;
        issue_next    = issue_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        covered_next  = covered_reg;
        found_next    = found_reg;
        target_next   = target_reg;
        removed_next  = removed_reg;
        live_next     = live_reg;
        hw_next       = hw_reg;
        status_next   = status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    func_next    = func;
                    set_next     = item_set[MAX_ITEMS-1:0];
                    issue_next   = '0;
                    pend_next    = 1'b0;
                    covered_next = 1'b0;
                    found_next   = 1'b0;
                    target_next  = '0;
                    removed_next = '0;
                end
            end
            ST_SCAN:
            begin
                issue_next    = issue_more ? issue_reg + CW'(1) : issue_reg;
                pend_next     = issue_more;
                pend_idx_next = issue_reg;
                if (sup_hit)
                begin
                    covered_next = 1'b1;
                end
                if (pass_done)
                begin
                    // restart the read pointer for the prune pass
                    issue_next = '0;
                    if (func_reg == FUNC_QUERY)
                    begin
                        status_next = STAT_QUERY;
                    end
                    else
                    begin
                        status_next = STAT_COVERED;
                    end
                end
            end
            ST_PRUNE:
            begin
                issue_next    = issue_more ? issue_reg + CW'(1) : issue_reg;
                pend_next     = issue_more;
                pend_idx_next = issue_reg;
                if (sub_hit)
                begin
                    removed_next = removed_reg + CW'(1);
                    live_next    = live_reg - CW'(1);
                end
                if (pend_reg && (!entry_valid || sub_hit) && !found_reg)
                begin
                    found_next  = 1'b1;
                    target_next = pend_idx_reg;
                end
            end
            ST_PLACE:
            begin
                if (found_reg)
                begin
                    status_next = STAT_INSERTED;
                    live_next   = live_reg + CW'(1);
                end
                else if (room)
                begin
                    status_next = STAT_INSERTED;
                    target_next = hw_reg;
                    hw_next     = hw_reg + CW'(1);
                    live_next   = live_reg + CW'(1);
                end
                else
                begin
                    status_next = STAT_FULL;
                    target_next = '0;
                end
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            live_reg  <= '0;
            hw_reg    <= '0;
            issue_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            live_reg  <= live_next;
            hw_reg    <= hw_next;
            issue_reg <= issue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        set_reg      <= set_next;
        pend_idx_reg <= pend_idx_next;
        covered_reg  <= covered_next;
        target_reg   <= target_next;
        removed_reg  <= removed_next;
        status_reg   <= status_next;
    end

    always_comb
    begin
        result.status        = status_reg;
        result.covered       = covered_reg;
        result.slot          = SLOT_W'(target_reg);
        result.removed_count = COUNT_W'(removed_reg);
        result.live_count    = COUNT_W'(live_reg);
    end

endmodule

// ===== rtl/maximal_set_registry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maximal_set_registry: table of maximal item sets
// Keeps item-set bitmaps so that no stored set contains another; inserts
// drop covered sets and evict subsets, queries report coverage.
// ----------------------------------------------------------------------------
// Scan: each pass reads the entries below the high-water mark (at most
//   CAPACITY), one entry per cycle through the single read port of the set
//   memory.
// Throughput: one transaction at a time; the next request is taken the cycle
//   after the result lands in the output register, which waits while a held
//   result is stalled.
// Reset: clears the sequencer, the high-water mark and the live count; the
//   set memory is not swept, since only entries below the mark are read.
// ----------------------------------------------------------------------------
module maximal_set_registry #(
    parameter int MAX_ITEMS = mss_pkg::MAX_ITEMS_DEF,
    parameter int CAPACITY  = mss_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          func,
    input  logic [mss_pkg::SET_W-1:0]     item_set,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [mss_pkg::STATUS_W-1:0]  status,
    output logic                          covered,
    output logic [mss_pkg::SLOT_W-1:0]    slot,
    output logic [mss_pkg::COUNT_W-1:0]   removed_count,
    output logic [mss_pkg::COUNT_W-1:0]   live_count
);
    import mss_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Memory port wiring between the sequencer and the set table.
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [MAX_ITEMS:0]   rd_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [MAX_ITEMS:0]   wr_data;

    // Finished transaction handed from the engine to the output register.
    logic                 out_ready;
    logic                 done;
    result_t              result;

    // Output register.
    logic                 rsp_valid_reg, rsp_valid_next;
    result_t              rsp_data_reg, rsp_data_next;

    mss_table #(
        .MAX_ITEMS (MAX_ITEMS),
        .CAPACITY  (CAPACITY)
    ) u_table (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    mss_engine #(
        .MAX_ITEMS (MAX_ITEMS),
        .CAPACITY  (CAPACITY)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .func      (func),
        .item_set  (item_set),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .out_ready (out_ready),
        .done      (done),
        .result    (result)
    );

    // The engine may hand over a result whenever the output register is
    // empty or is being drained in this cycle.
    assign out_ready = !rsp_valid_reg || !rsp_stall;

    // Load a new result on done; drop the held one once it is taken.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (done)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = result;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = rsp_data_reg.status;
    assign covered       = rsp_data_reg.covered;
    assign slot          = rsp_data_reg.slot;
    assign removed_count = rsp_data_reg.removed_count;
    assign live_count    = rsp_data_reg.live_count;

endmodule

// ===== rtl/mss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_checker: port-level checks for the maximal set registry
// Watches the response channel for consistency between status and the
// other result fields.
// ----------------------------------------------------------------------------
module mss_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic [mss_pkg::STATUS_W-1:0]  status,
    input  logic                          covered,
    input  logic [mss_pkg::SLOT_W-1:0]    slot,
    input  logic [mss_pkg::COUNT_W-1:0]   removed_count
);
    import mss_pkg::*;

    // Hold a stalled response.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(slot))
        else $error("stalled response changed");

    // Covered is set on an insert only when it is dropped as covered.
    a_covered_insert: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STAT_INSERTED || status == STAT_FULL) |-> !covered)
        else $error("covered flagged on an uncovered insert");

    // A slot number is reported only for a successful insert.
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != STAT_INSERTED |-> slot == '0)
        else $error("slot nonzero without insert");

    // Nothing is evicted unless the set goes through the prune pass.
    a_no_removal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STAT_COVERED || status == STAT_QUERY ||
                      status == STAT_FULL) |-> removed_count == '0)
        else $error("entries removed without an insert");

endmodule

bind maximal_set_registry mss_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .covered       (covered),
    .slot          (slot),
    .removed_count (removed_count)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the maximal set registry
// Drives insert and query transactions through the request channel, runs a
// bit-accurate software copy of the set table alongside and compares every
// response field against it or a hand-typed row. A short directed table
// comes first, followed by random traffic in three phases: small-universe
// churn, a table fill with wide sets and mixed traffic on a full table.
// ----------------------------------------------------------------------------
module tb;

    import mss_pkg::*;

    localparam int TABLE_DEPTH  = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1125;
    localparam int CHURN_END    = 500;
    localparam int FILL_END     = 850;
    localparam int DRAIN_CYCLES = 600;

    // One row of the directed table. Where typed is set, want is the response
    // spelled out by hand; otherwise the table mirror supplies it.
    typedef struct {
        logic                  fn;
        logic [SET_W-1:0]      bits;
        bit                    typed;
        result_t               want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    logic                  func = FUNC_INSERT;
    logic [SET_W-1:0]      item_set = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic                  covered;
    logic [SLOT_W-1:0]     slot;
    logic [COUNT_W-1:0]    removed_count;
    logic [COUNT_W-1:0]    live_count;

    // Software copy of the set table
    logic [SET_W-1:0]      set_table [TABLE_DEPTH];
    bit                    set_live  [TABLE_DEPTH];
    int unsigned           table_mark = 0;
    int unsigned           live_total = 0;

    // Responses still owed by the block, oldest first
    result_t               pending_results [$];
    int unsigned           fail_count = 0;

    // Idle control for both channels
    bit                    tx_burst = 1'b0;
    bit                    rx_burst = 1'b0;
    bit                    rsp_fresh = 1'b1;
    int unsigned           stall_left = 0;
    int unsigned           rx_seen = 0;

    logic [SET_W-1:0]      churn_mask;

    stim_row_t directed_rows [23] = '{
        // empty table: nothing covers anything, the empty set included
        '{FUNC_QUERY,  64'h0,                   1'b1, '{STAT_QUERY,    1'b0, 8'd0, 9'd0, 9'd0}},
        '{FUNC_QUERY,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{STAT_QUERY,    1'b0, 8'd0, 9'd0, 9'd0}},
        // empty set goes into an empty table, then a second copy is covered
        '{FUNC_INSERT, 64'h0,                   1'b1, '{STAT_INSERTED, 1'b0, 8'd0, 9'd0, 9'd1}},
        '{FUNC_INSERT, 64'h0,                   1'b1, '{STAT_COVERED,  1'b1, 8'd0, 9'd0, 9'd1}},
        '{FUNC_QUERY,  64'h0,                   1'b1, '{STAT_QUERY,    1'b1, 8'd0, 9'd0, 9'd1}},
        '{FUNC_QUERY,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{STAT_QUERY,    1'b0, 8'd0, 9'd0, 9'd1}},
        // any non-empty insert evicts the stored empty set and reuses its slot
        '{FUNC_INSERT, 64'h1,                   1'b1, '{STAT_INSERTED, 1'b0, 8'd0, 9'd1, 9'd1}},
        '{FUNC_INSERT, 64'h2,                   1'b1, '{STAT_INSERTED, 1'b0, 8'd1, 9'd0, 9'd2}},
        '{FUNC_INSERT, 64'h3,                   1'b1, '{STAT_INSERTED, 1'b0, 8'd0, 9'd2, 9'd1}},
        '{FUNC_INSERT, 64'h1,                   1'b1, '{STAT_COVERED,  1'b1, 8'd0, 9'd0, 9'd1}},
        // top item bit, and a hole below the mark is filled before appending
        '{FUNC_INSERT, 64'h8000_0000_0000_0000, 1'b1, '{STAT_INSERTED, 1'b0, 8'd1, 9'd0, 9'd2}},
        '{FUNC_QUERY,  64'h8000_0000_0000_0001, 1'b1, '{STAT_QUERY,    1'b0, 8'd0, 9'd0, 9'd2}},
        '{FUNC_INSERT, 64'h8000_0000_0000_0003, 1'b1, '{STAT_INSERTED, 1'b0, 8'd0, 9'd2, 9'd1}},
        '{FUNC_INSERT, 64'h4,                   1'b1, '{STAT_INSERTED, 1'b0, 8'd1, 9'd0, 9'd2}},
        '{FUNC_INSERT, 64'h0,                   1'b1, '{STAT_COVERED,  1'b1, 8'd0, 9'd0, 9'd2}},
        '{FUNC_INSERT, 64'h8,                   1'b1, '{STAT_INSERTED, 1'b0, 8'd2, 9'd0, 9'd3}},
        // equal set is covered
        '{FUNC_QUERY,  64'h8000_0000_0000_0003, 1'b1, '{STAT_QUERY,    1'b1, 8'd0, 9'd0, 9'd3}},
        '{FUNC_QUERY,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{STAT_QUERY,    1'b0, 8'd0, 9'd0, 9'd3}},
        // wide patterns, left to the mirror
        '{FUNC_INSERT, 64'h5555_5555_5555_5555, 1'b0, '0},
        '{FUNC_QUERY,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
        '{FUNC_INSERT, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
        '{FUNC_QUERY,  64'h3,                   1'b0, '0},
        '{FUNC_INSERT, 64'hFEDC_BA98_7654_3210, 1'b0, '0}
    };

    maximal_set_registry dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .func          (func),
        .item_set      (item_set),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .covered       (covered),
        .slot          (slot),
        .removed_count (removed_count),
        .live_count    (live_count)
    );

    always #2 clk = ~clk;

    // Apply one transaction to the table copy and return the response it owes.
    // A set is covered when it has no item outside some live entry.
    function automatic result_t registry_apply(logic fn, logic [SET_W-1:0] bits);
        result_t     res;
        bit          hit;
        int          target;
        int unsigned evicted;
        res     = '0;
        hit     = 1'b0;
        target  = -1;
        evicted = 0;
        for (int i = 0; i < table_mark; i++)
            if (set_live[i] && (bits & ~set_table[i]) == '0)
                hit = 1'b1;
        if (fn == FUNC_QUERY) begin
            res.status  = STAT_QUERY;
            res.covered = hit;
        end
        else if (hit) begin
            res.status  = STAT_COVERED;
            res.covered = 1'b1;
        end
        else begin
            // drop every live subset, then take the lowest hole or append
            for (int i = 0; i < table_mark; i++) begin
                if (set_live[i] && (set_table[i] & ~bits) == '0) begin
                    set_live[i] = 1'b0;
                    live_total--;
                    evicted++;
                end
            end
            for (int i = 0; i < table_mark; i++)
                if (!set_live[i] && target < 0)
                    target = i;
            if (target < 0 && table_mark < TABLE_DEPTH) begin
                target = table_mark;
                table_mark++;
            end
            if (target >= 0) begin
                set_table[target] = bits;
                set_live[target]  = 1'b1;
                live_total++;
                res.status = STAT_INSERTED;
                res.slot   = target[SLOT_W-1:0];
            end
            else
                res.status = STAT_FULL;
            res.removed_count = evicted[COUNT_W-1:0];
        end
        res.live_count = live_total[COUNT_W-1:0];
        return res;
    endfunction

    function automatic logic [SET_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Fetch a live entry from the copy, starting at a random slot.
    function automatic bit pick_stored(output logic [SET_W-1:0] bits);
        int start;
        int idx;
        bits = '0;
        if (live_total == 0)
            return 1'b0;
        start = $urandom_range(0, table_mark - 1);
        for (int k = 0; k < table_mark; k++) begin
            idx = (start + k) % table_mark;
            if (set_live[idx]) begin
                bits = set_table[idx];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Present one transaction after a random gap and hold it until taken.
    // The table copy advances at the edge where the block accepts it.
    task automatic send_item(logic fn, logic [SET_W-1:0] bits, bit typed, result_t want);
        int      gap;
        result_t predicted;
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        func      <= fn;
        item_set  <= bits;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = registry_apply(fn, bits);
        pending_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Response back-pressure: a hold drawn at every accepted response, and
    // sometimes another once a fresh response shows up, so that stalls land
    // both on an idle channel and on a waiting payload.
    always @(negedge clk) begin
        if (rsp_valid && rsp_fresh) begin
            rsp_fresh = 1'b0;
            if (!rx_burst && $urandom_range(0, 1) == 1)
                stall_left = $urandom_range(1, 14);
        end
        if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else
            rsp_stall <= 1'b0;
    end

    // Compare every accepted response with the oldest owed one.
    always @(posedge clk) begin : response_check
        result_t want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
                $error("response with nothing outstanding: status %0d", status);
                fail_count++;
            end
            else begin
                want = pending_results.pop_front();
                if (status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fail_count++;
                end
                if (covered !== want.covered) begin
                    $error("covered: expected %0d, got %0d", want.covered, covered);
                    fail_count++;
                end
                if (slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, slot);
                    fail_count++;
                end
                if (removed_count !== want.removed_count) begin
                    $error("removed_count: expected %0d, got %0d",
                           want.removed_count, removed_count);
                    fail_count++;
                end
                if (live_count !== want.live_count) begin
                    $error("live_count: expected %0d, got %0d", want.live_count, live_count);
                    fail_count++;
                end
            end
            // switch between stall-free stretches and random holds now and then
            if (rx_seen % 64 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            rx_seen++;
            rsp_fresh  = 1'b1;
            stall_left = rx_burst ? 0 : $urandom_range(0, 14);
        end
    end

    // Stimulus: reset, directed table, then three random phases.
    initial begin : stimulus
        logic             fn;
        logic [SET_W-1:0] bits;
        logic [SET_W-1:0] stored;
        bit               found;
        int unsigned      roll;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].fn, directed_rows[i].bits,
                      directed_rows[i].typed, directed_rows[i].want);

        churn_mask = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0)
                tx_burst = ($urandom_range(0, 3) == 0);
            // small universes keep sets overlapping, so evictions and cover
            // hits stay frequent; move to a new universe every 40 items
            if (n % 40 == 0) begin
                churn_mask = '0;
                while ($countones(churn_mask) < 10)
                    churn_mask[$urandom_range(0, SET_W - 1)] = 1'b1;
            end
            found = pick_stored(stored);
            roll  = $urandom_range(0, 99);
            fn    = FUNC_INSERT;
            bits  = rand_word() & churn_mask;
            if (n < CHURN_END) begin
                if (roll < 65)
                    fn = (roll >= 50) ? FUNC_QUERY : FUNC_INSERT;
                else if (roll < 75 && found) begin
                    bits = stored & rand_word();
                    fn   = $urandom_range(0, 1) ? FUNC_QUERY : FUNC_INSERT;
                end
                else if (roll < 85 && found)
                    bits = stored | (rand_word() & rand_word() & rand_word());
                else if (roll < 90 && found) begin
                    bits = stored;
                    fn   = $urandom_range(0, 1) ? FUNC_QUERY : FUNC_INSERT;
                end
                else if (roll >= 90) begin
                    bits = rand_word();
                    fn   = (roll < 97) ? FUNC_QUERY : FUNC_INSERT;
                end
            end
            else if (n < FILL_END) begin
                // wide random sets hardly ever contain each other: fill the
                // table until inserts come back full
                if (roll < 80)
                    bits = rand_word();
                else if (roll < 90 && found) begin
                    bits = stored & rand_word();
                    fn   = FUNC_QUERY;
                end
                else if (found)
                    bits = stored | (rand_word() & rand_word() & rand_word());
                else
                    bits = rand_word();
            end
            else begin
                // full table: supersets open holes, wide sets hit the limit
                if (roll < 30)
                    bits = rand_word();
                else if (roll < 50 && found)
                    bits = stored | (rand_word() & rand_word() & rand_word());
                else if (roll < 70 && found) begin
                    bits = stored & rand_word();
                    fn   = $urandom_range(0, 1) ? FUNC_QUERY : FUNC_INSERT;
                end
                else if (roll < 80 && found) begin
                    bits = stored;
                    fn   = $urandom_range(0, 1) ? FUNC_QUERY : FUNC_INSERT;
                end
                else
                    fn = $urandom_range(0, 1) ? FUNC_QUERY : FUNC_INSERT;
            end
            send_item(fn, bits, 1'b0, '0);
        end
        req_valid <= 1'b0;

        // drain what is outstanding, then leave room for a stray response
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("maximal_set_registry: match");
        else
            $display("maximal_set_registry: mismatch");
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #12_000_000;
        $display("maximal_set_registry: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mss_pkg.sv
rtl/mss_table.sv
rtl/mss_engine.sv
rtl/maximal_set_registry.sv
rtl/mss_checker.sv
sim/tb.sv
